[src/page_framebuffer_rect_engine_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the page framebuffer rectangle engine
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_RECT_ENGINE_MACROS_SVH
`define PAGE_FRAMEBUFFER_RECT_ENGINE_MACROS_SVH

// check a property at every clock edge out of reset
`define PFRE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a condition never holds
`define PFRE_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[src/pfre_pkg.sv]
// ---------------------------------------------------------------------------
// pfre_pkg
// Shared types and helpers of the page framebuffer rectangle engine.
// ---------------------------------------------------------------------------
package pfre_pkg;

	localparam int PAGE_HEIGHT = 8;

	// kinds of an input word
	localparam logic KIND_DRAW = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// modify operation carried with one byte access
	typedef struct packed {
		logic       clear;     // write zero, ignore stored byte
		logic       erase;     // apply area mask
		logic       black;     // area mask sets (1) or clears (0)
		logic [7:0] area_mask; // rows of the area in this page
		logic [7:0] set_mask;  // border rows set afterwards
	} mod_t;

	// apply one modify operation to a stored byte
	function automatic logic [7:0] apply_mod(input mod_t op, input logic [7:0] old);
		logic [7:0] v;
		v = old;
		if (op.erase) begin
			v = op.black ? (v | op.area_mask) : (v & ~op.area_mask);
		end
		v = v | op.set_mask;
		return op.clear ? 8'h00 : v;
	endfunction

endpackage

[src/pfre_ram.sv]
// ---------------------------------------------------------------------------
// pfre_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pfre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 504,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[src/pfre_walk.sv]
// ---------------------------------------------------------------------------
// pfre_walk
// Access sequencer: clearing pass after reset, then one walk per rectangle
// over its columns and the panel pages, with the byte masks for each access.
// ---------------------------------------------------------------------------
module pfre_walk #(
	parameter int COLUMNS = 84,
	parameter int ROWS = 48,
	parameter int PAGES = 6,
	localparam int DEPTH = COLUMNS * PAGES,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int PG_W = (PAGES > 1) ? $clog2(PAGES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [7:0]          left_x,
	input  logic [7:0]          top_y,
	input  logic [7:0]          extent_x,
	input  logic [7:0]          extent_y,
	input  logic                draw_border,
	input  logic                erase_inside,
	input  logic                fill_black,
	output logic                idle,
	output logic                issue_vld,
	output logic [AW-1:0]       issue_addr,
	output pfre_pkg::mod_t      issue_mod
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_DRAW  = 3'b100
	} state_t;

	localparam logic [8:0] ROWS_LIM = 9'(ROWS);
	localparam logic [7:0] COL_LIM = 8'(COLUMNS);
	localparam logic [PG_W-1:0] PG_LAST = PG_W'(PAGES - 1);
	localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

	state_t          state_q;
	logic [AW-1:0]   clr_addr_q;
	logic [7:0]      col_i_q;
	logic [PG_W-1:0] pg_q;
	logic [7:0]      x0_q, y0_q, ex_q, ey_q;
	logic            border_q, erase_q, black_q;

	logic [7:0] col_x;
	logic       on_col;
	logic       edge_col;
	logic       last_col;
	logic [7:0] page_row;
	logic [7:0] bot_y;
	logic [7:0] area_mask;
	logic [7:0] edge_rows;
	logic [7:0] set_mask;
	logic       touch;

	// current column and first row of current page
	assign col_x    = x0_q + col_i_q;
	assign on_col   = col_x < COL_LIM;
	assign edge_col = (col_i_q == 8'd0) || (col_i_q == ex_q);
	assign last_col = col_i_q == ex_q;
	assign page_row = 8'(pg_q) << 3;
	assign bot_y    = y0_q + ey_q;

	// per-bit row membership within the current page
	for (genvar n = 0; n < pfre_pkg::PAGE_HEIGHT; n++) begin : g_row
		logic [7:0] row_y;
		logic [7:0] row_off;
		logic       on_panel;
		assign row_y        = page_row | 8'(n);
		assign row_off      = row_y - y0_q;
		assign on_panel     = {1'b0, row_y} < ROWS_LIM;
		assign area_mask[n] = on_panel && (row_off <= ey_q);
		assign edge_rows[n] = on_panel && ((row_y == y0_q) || (row_y == bot_y));
	end

	assign set_mask = border_q ? (edge_col ? area_mask : edge_rows) : 8'h00;
	assign touch    = on_col && ((erase_q && (area_mask != 8'h00)) || (set_mask != 8'h00));

	// issue at most one byte access per cycle
	always_comb begin
		issue_vld  = 1'b0;
		issue_addr = clr_addr_q;
		issue_mod  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				issue_vld       = 1'b1;
				issue_mod.clear = 1'b1;
			end
			ST_DRAW: begin
				issue_vld           = touch;
				issue_addr          = AW'(AW'(col_x) * AW'(PAGES) + AW'(pg_q));
				issue_mod.erase     = erase_q;
				issue_mod.black     = black_q;
				issue_mod.area_mask = area_mask;
				issue_mod.set_mask  = set_mask;
			end
			default: begin
			end
		endcase
	end

	assign idle = state_q == ST_IDLE;

	// sequence state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			col_i_q    <= '0;
			pg_q       <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == ADDR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DRAW;
						col_i_q <= '0;
						pg_q    <= '0;
					end
				end
				ST_DRAW: begin
					// skip off-panel columns whole, else step pages
					if (!on_col || (pg_q == PG_LAST)) begin
						pg_q <= '0;
						if (last_col) begin
							state_q <= ST_IDLE;
						end else begin
							col_i_q <= col_i_q + 8'd1;
						end
					end else begin
						pg_q <= pg_q + PG_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold rectangle fields for the walk
	always_ff @(posedge clk) begin
		if (start && (state_q == ST_IDLE)) begin
			x0_q     <= left_x;
			y0_q     <= top_y;
			ex_q     <= extent_x;
			ey_q     <= extent_y;
			border_q <= draw_border;
			erase_q  <= erase_inside;
			black_q  <= fill_black;
		end
	end

endmodule

[src/page_framebuffer_rect_engine.sv]
// Read word: the result passes the frame memory read register, then the output
// register; the next word waits while the read is in flight or its result is held.
// Draw word: the walk steps every page of each rectangle column on the panel and
// skips each column off it whole, then the last write-back drains.
// Reset clears control at once, then a clearing pass writes COLUMNS*PAGES zero
// bytes; no word is accepted until the pass and its last write-back are done.
// ---------------------------------------------------------------------------
// page_framebuffer_rect_engine
// Monochrome page-addressed framebuffer with rectangle fill, border and
// byte readback, held in one frame memory updated by read-modify-write.
// ---------------------------------------------------------------------------
`include "page_framebuffer_rect_engine_macros.svh"

module page_framebuffer_rect_engine #(
	parameter int COLUMNS = 84,
	parameter int ROWS = 48,
	parameter int PAGES = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] left_x,
	input  logic [7:0] top_y,
	input  logic [7:0] extent_x,
	input  logic [7:0] extent_y,
	input  logic       draw_border,
	input  logic       erase_inside,
	input  logic       fill_black,
	input  logic [6:0] read_column,
	input  logic [2:0] read_page,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_byte
);

	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [7:0] COL_LIM = 8'(COLUMNS);
	localparam logic [5:0] PG_LIM = 6'(PAGES);

	logic                 in_acc;
	logic                 rd_acc;
	logic                 walk_idle;
	logic                 issue_vld;
	logic [AW-1:0]        issue_addr;
	pfre_pkg::mod_t       issue_mod;

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [7:0]           rd_data;
	logic [AW-1:0]        host_addr;
	logic                 host_zero;

	logic                 wr_vld_s1;
	logic [AW-1:0]        wr_addr_s1;
	pfre_pkg::mod_t       mod_s1;
	logic                 rd_vld_s1;
	logic                 rd_zero_s1;
	logic                 out_valid_q;
	logic [7:0]           read_byte_q;

	// accept only with the walk idle, the pipe empty and room for a result
	assign in_stall = !walk_idle || wr_vld_s1 || rd_vld_s1 || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign rd_acc   = in_acc && (kind == pfre_pkg::KIND_READ);

	pfre_walk #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.PAGES   (PAGES)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_acc && (kind == pfre_pkg::KIND_DRAW)),
		.left_x       (left_x),
		.top_y        (top_y),
		.extent_x     (extent_x),
		.extent_y     (extent_y),
		.draw_border  (draw_border),
		.erase_inside (erase_inside),
		.fill_black   (fill_black),
		.idle         (walk_idle),
		.issue_vld    (issue_vld),
		.issue_addr   (issue_addr),
		.issue_mod    (issue_mod)
	);

	// host read address and range check
	assign host_addr = AW'(AW'(read_column) * AW'(PAGES) + AW'(read_page));
	assign host_zero = ({1'b0, read_column} >= COL_LIM) || ({3'b000, read_page} >= PG_LIM);

	// select read port between host read and walk
	always_comb begin
		if (rd_acc) begin
			rd_en   = 1'b1;
			rd_addr = host_addr;
		end else begin
			rd_en   = issue_vld;
			rd_addr = issue_addr;
		end
	end

	pfre_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_frame (
		.clk     (clk),
		.wr_en   (wr_vld_s1),
		.wr_addr (wr_addr_s1),
		.wr_data (pfre_pkg::apply_mod(mod_s1, rd_data)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// advance control of the write-back and read stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_s1   <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_vld_s1 <= issue_vld;
			rd_vld_s1 <= rd_acc;
			if (rd_vld_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold stage payload
	always_ff @(posedge clk) begin
		wr_addr_s1 <= issue_addr;
		mod_s1     <= issue_mod;
		rd_zero_s1 <= host_zero;
		if (rd_vld_s1) begin
			read_byte_q <= rd_zero_s1 ? 8'h00 : rd_data;
		end
	end

	assign out_valid = out_valid_q;
	assign read_byte = read_byte_q;

	`PFRE_ASSERT(a_read_latency, rd_acc |-> ##2 out_valid_q, "read word gave no result")
	`PFRE_NEVER(a_accept_busy, in_acc && !walk_idle, "word accepted while walk busy")
	`PFRE_NEVER(a_stage_overlap, wr_vld_s1 && rd_vld_s1, "write-back and read overlap")
	`PFRE_NEVER(a_result_overrun, rd_vld_s1 && out_valid_q && out_stall, "result overwritten")

endmodule

[tb/sv/frame_readback_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// frame_readback_checker
// Watches both channels of the page framebuffer rectangle engine, keeps a
// shadow copy of the frame, predicts every read-back byte and compares it
// with the byte the engine returns.
// ---------------------------------------------------------------------------
module frame_readback_checker #(
	parameter int COLUMNS = 84,
	parameter int ROWS = 48,
	parameter int PAGES = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       kind,
	input  logic [7:0] left_x,
	input  logic [7:0] top_y,
	input  logic [7:0] extent_x,
	input  logic [7:0] extent_y,
	input  logic       draw_border,
	input  logic       erase_inside,
	input  logic       fill_black,
	input  logic [6:0] read_column,
	input  logic [2:0] read_page,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] read_byte,
	output int         mismatch_count,
	output int         bytes_waiting,
	output int         bytes_checked
);

	localparam int REPORT_CAP = 20;

	logic [7:0] frame_shadow [COLUMNS*PAGES];
	logic [7:0] byte_queue [$];
	int errors = 0;
	int checked = 0;

	// stored byte at one column and page; zero off the panel
	function automatic logic [7:0] stored_byte(input logic [6:0] col, input logic [2:0] pg);
		if (col < COLUMNS && pg < PAGES)
			return frame_shadow[col*PAGES + pg];
		return 8'h00;
	endfunction

	// apply one rectangle word to the shadow frame, one column byte at a time
	function automatic void paint_rect(input logic [7:0] x0, input logic [7:0] y0,
			input logic [7:0] ex, input logic [7:0] ey,
			input logic border, input logic erase, input logic black);
		logic [255:0] span_rows;
		logic [255:0] edge_rows;
		logic [7:0] x, x1, y, y1, area, edges, v;
		int i, j, p, idx;
		span_rows = '0;
		edge_rows = '0;
		x1 = x0 + ex;
		y1 = y0 + ey;
		// mark the visible rows of the area, wrapping at 256
		for (j = 0; j <= ey; j++) begin
			y = y0 + 8'(j);
			if (y < ROWS)
				span_rows[y] = 1'b1;
		end
		if (y0 < ROWS)
			edge_rows[y0] = 1'b1;
		if (y1 < ROWS)
			edge_rows[y1] = 1'b1;
		// walk the columns of the area; off-panel columns leave nothing
		for (i = 0; i <= ex; i++) begin
			x = x0 + 8'(i);
			if (x < COLUMNS) begin
				for (p = 0; p < PAGES; p++) begin
					area = span_rows[p*pfre_pkg::PAGE_HEIGHT +: 8];
					edges = edge_rows[p*pfre_pkg::PAGE_HEIGHT +: 8];
					idx = x*PAGES + p;
					v = frame_shadow[idx];
					if (erase)
						v = black ? (v | area) : (v & ~area);
					if (border) begin
						v = v | edges;
						if (x == x0 || x == x1)
							v = v | area;
					end
					frame_shadow[idx] = v;
				end
			end
		end
	endfunction

	// compare returned words, then predict accepted input words
	always @(posedge clk or negedge arst_n) begin : watch
		logic [7:0] expected_byte;
		if (!arst_n) begin
			foreach (frame_shadow[k])
				frame_shadow[k] = 8'h00;
			byte_queue.delete();
			errors = 0;
			checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (byte_queue.size() == 0) begin
					errors++;
					if (errors <= REPORT_CAP)
						$display("%0t: read_byte %02h returned with no read pending",
							$time, read_byte);
				end else begin
					expected_byte = byte_queue.pop_front();
					checked++;
					if (read_byte !== expected_byte) begin
						errors++;
						if (errors <= REPORT_CAP)
							$display("%0t: read_byte mismatch, expected %02h actual %02h",
								$time, expected_byte, read_byte);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (kind == pfre_pkg::KIND_READ)
					byte_queue.push_back(stored_byte(read_column, read_page));
				else
					paint_rect(left_x, top_y, extent_x, extent_y,
						draw_border, erase_inside, fill_black);
			end
		end
		mismatch_count <= errors;
		bytes_waiting <= byte_queue.size();
		bytes_checked <= checked;
	end

endmodule

[tb/sv/tb_page_framebuffer_rect_engine.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_page_framebuffer_rect_engine
// Drives rectangle and read-back words into the page framebuffer engine:
// a directed opening on wrap, full extents, off-panel and out-of-range
// cases, then randomized words in bursts against a stalling receiver.
// Checking is done by frame_readback_checker beside the engine.
// ---------------------------------------------------------------------------
module tb_page_framebuffer_rect_engine;

	localparam int COLUMNS = 84;
	localparam int ROWS = 48;
	localparam int PAGES = 6;
	localparam int RANDOM_WORDS = 550;
	localparam int DRAIN_CYCLES = 256*PAGES + 16;
	localparam int IDLE_LIMIT = 20000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       kind = pfre_pkg::KIND_DRAW;
	logic [7:0] left_x = 8'h00;
	logic [7:0] top_y = 8'h00;
	logic [7:0] extent_x = 8'h00;
	logic [7:0] extent_y = 8'h00;
	logic       draw_border = 1'b0;
	logic       erase_inside = 1'b0;
	logic       fill_black = 1'b0;
	logic [6:0] read_column = 7'h00;
	logic [2:0] read_page = 3'h0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] read_byte;

	int mismatch_count;
	int bytes_waiting;
	int bytes_checked;

	int idle_cycles = 0;
	int burst_left = 0;
	int draws_sent = 0;
	int reads_sent = 0;
	logic [15:0] stall_phase = '0;
	logic [1:0]  stall_mode = 2'd0;

	page_framebuffer_rect_engine #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.PAGES(PAGES)
	) i_dut (.*);

	frame_readback_checker #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.PAGES(PAGES)
	) i_checker (.*);

	always #6 clk = ~clk;

	// count cycles in which no word moves on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// stall the result channel, switching pattern whenever the phase counter's low byte wraps
	always @(posedge clk) begin
		stall_phase <= stall_phase + 16'd1;
		if (stall_phase[7:0] == 8'd0)
			stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
			2'd0: begin
				out_stall <= 1'b0;
			end
			2'd1: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			2'd2: begin
				out_stall <= (stall_phase[2:0] < 3'd3);
			end
			default: begin
				out_stall <= ($urandom_range(0, 1) == 1);
			end
		endcase
	end

	// present one word and hold it until accepted; open a random, possibly empty, gap between bursts
	task automatic push_word(input logic k, input logic [7:0] lx, input logic [7:0] ty,
			input logic [7:0] ex, input logic [7:0] ey, input logic bd, input logic er,
			input logic fb, input logic [6:0] col, input logic [2:0] pg);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		kind <= k;
		left_x <= lx;
		top_y <= ty;
		extent_x <= ex;
		extent_y <= ey;
		draw_border <= bd;
		erase_inside <= er;
		fill_black <= fb;
		read_column <= col;
		read_page <= pg;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		if (k == pfre_pkg::KIND_READ)
			reads_sent++;
		else
			draws_sent++;
	endtask

	// read one byte; the rectangle fields carry noise
	task automatic read_word(input logic [6:0] col, input logic [2:0] pg);
		push_word(pfre_pkg::KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), col, pg);
	endtask

	// draw one rectangle; the read fields carry noise
	task automatic draw_word(input logic [7:0] lx, input logic [7:0] ty,
			input logic [7:0] ex, input logic [7:0] ey,
			input logic bd, input logic er, input logic fb);
		push_word(pfre_pkg::KIND_DRAW, lx, ty, ex, ey, bd, er, fb,
			7'($urandom), 3'($urandom));
	endtask

	// pick a random word: mostly small rectangles near the panel, some reads
	task automatic random_word();
		logic [7:0] lx, ty, ex, ey;
		logic [6:0] col;
		logic [2:0] pg;
		int size_class;
		if ($urandom_range(0, 99) < 40) begin
			col = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
				: 7'($urandom_range(0, COLUMNS - 1));
			pg = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(0, PAGES - 1));
			read_word(col, pg);
		end else begin
			lx = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, COLUMNS + 7));
			ty = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, ROWS + 7));
			size_class = $urandom_range(0, 49);
			if (size_class == 0) begin
				ex = 8'($urandom);
				ey = 8'($urandom);
			end else if (size_class < 5) begin
				ex = 8'($urandom);
				ey = 8'($urandom_range(0, 63));
			end else begin
				ex = 8'($urandom_range(0, 15));
				ey = 8'($urandom_range(0, 15));
			end
			draw_word(lx, ty, ex, ey, 1'($urandom), 1'($urandom), 1'($urandom));
		end
	endtask

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// cleared frame and out-of-range reads
		read_word(7'd0, 3'd0);
		read_word(7'd83, 3'd5);
		read_word(7'd127, 3'd7);
		read_word(7'd84, 3'd0);
		read_word(7'd0, 3'd6);
		// full extent fill with wrap, then read back
		draw_word(8'd0, 8'd0, 8'd255, 8'd255, 1'b0, 1'b1, 1'b1);
		read_word(7'd83, 3'd5);
		read_word(7'd40, 3'd2);
		// cleared area with a border on top of a black frame
		draw_word(8'd10, 8'd5, 8'd20, 8'd12, 1'b1, 1'b1, 1'b0);
		read_word(7'd10, 3'd0);
		read_word(7'd20, 3'd1);
		read_word(7'd30, 3'd2);
		// clear everything, then a border that wraps past both edges
		draw_word(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0);
		draw_word(8'd250, 8'd250, 8'd10, 8'd10, 1'b1, 1'b0, 1'b0);
		read_word(7'd0, 3'd0);
		read_word(7'd4, 3'd0);
		// no flags: nothing changes
		draw_word(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b1);
		read_word(7'd2, 3'd0);
		// single pixel at the last panel position
		draw_word(8'd83, 8'd47, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);
		read_word(7'd83, 3'd5);
		// entirely off the panel
		draw_word(8'd200, 8'd100, 8'd30, 8'd30, 1'b1, 1'b1, 1'b1);
		// area running past the bottom row
		draw_word(8'd0, 8'd44, 8'd3, 8'd8, 1'b0, 1'b1, 1'b1);
		read_word(7'd0, 3'd5);
		read_word(7'd3, 3'd5);

		repeat (RANDOM_WORDS) random_word();

		// drop valid and drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (bytes_waiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d rectangle words and %0d read words", draws_sent, reads_sent);
		$display("%0d bytes read back and compared against the shadow frame", bytes_checked);
		if (mismatch_count == 0 && bytes_waiting == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
